// File: rtl/tan_pkg.sv
// Shared types and constants of the tilt average and normalize unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package tan_pkg;

  localparam int unsigned SAMPLE_W = 16;  // raw accelerometer sample
  localparam int unsigned TILT_W   = 16;  // Q1.14 result component
  localparam int unsigned FRAC_W   = 14;  // fraction bits of the result
  localparam int unsigned NORM_W   = 62;  // normalized squared length
  localparam int unsigned ROOT_W   = 31;  // square root of the normalized length
  localparam int unsigned QUO_W    = 16;  // quotient bits per component
  localparam int unsigned STEP_W   = 5;   // sequencer step counter
  localparam int unsigned AXES     = 3;

  localparam logic [QUO_W-1:0] UNIT_Q14 = 16'd16384;

  // Axis select codes of the shared squaring multiplier.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic       capture;    // latch the incoming sample
    logic       update;     // ring write and running sum update
    logic       sq_first;   // clear the length accumulator, load magnitudes
    logic       sq_prod;    // square the selected axis
    logic       sq_acc;     // add the last product to the length
    logic [1:0] sq_axis;
    logic       norm_init;  // load the normalizer with the squared length
    logic       norm_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;   // move the result into the output register
  } tan_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic norm_done;
    logic out_free;
  } tan_sts_t;

endpackage

// File: rtl/tan_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; no package needed.
module tan_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tan_ctrl.sv
// Sequencer of the tilt average and normalize unit: steps the datapath through
// sum update, squaring, normalization, square root and division. Uses tan_pkg.
module tan_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tan_pkg::tan_sts_t sts_i,
  output tan_pkg::tan_cmd_t cmd_o
);
  import tan_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL,
    ST_CHK,
    ST_NORM,
    ST_SQRT,
    ST_DIVI,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic   [STEP_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        cnt_d        = '0;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        // The product of one axis is added in the cycle after it is formed.
        cmd_o.sq_axis  = cnt_q[1:0];
        cmd_o.sq_first = (cnt_q[1:0] == AXIS_X);
        cmd_o.sq_prod  = (cnt_q[1:0] != AXIS_NONE);
        cmd_o.sq_acc   = (cnt_q[1:0] != AXIS_X);
        if (cnt_q[1:0] == AXIS_NONE) begin
          cnt_d   = '0;
          state_d = ST_CHK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CHK: begin
        cmd_o.norm_init = 1'b1;
        state_d         = sts_i.len_zero ? ST_DONE : ST_NORM;
      end
      ST_NORM: begin
        if (sts_i.norm_done) begin
          cmd_o.sqrt_init = 1'b1;
          cnt_d           = '0;
          state_d         = ST_SQRT;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == STEP_W'(ROOT_W - 1)) begin
          state_d = ST_DIVI;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == STEP_W'(QUO_W - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_accept_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_UPD)
    else $error("accepted transaction did not start the sum update");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while the output register is still occupied");

  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.update, cmd_o.norm_step, cmd_o.sqrt_step,
              cmd_o.div_init, cmd_o.div_step, cmd_o.out_load}))
    else $error("more than one datapath phase commanded at once");

  a_sqrt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQRT |-> cnt_q < STEP_W'(ROOT_W))
    else $error("square root step counter out of range");

endmodule

// File: rtl/tan_datapath.sv
// Datapath of the tilt average and normalize unit: sample ring, running sums,
// squaring, normalizer, bit-serial square root, three divider lanes and the
// output register. Uses tan_pkg and tan_ram.
module tan_datapath #(
  parameter int unsigned OVERSAMPLE = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tan_pkg::tan_cmd_t                    cmd_i,
  output tan_pkg::tan_sts_t                    sts_o,
  input  logic signed [tan_pkg::SAMPLE_W-1:0]  accel_x_i,
  input  logic signed [tan_pkg::SAMPLE_W-1:0]  accel_y_i,
  input  logic signed [tan_pkg::SAMPLE_W-1:0]  accel_z_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [tan_pkg::TILT_W-1:0]    tilt_x_o,
  output logic signed [tan_pkg::TILT_W-1:0]    tilt_y_o,
  output logic signed [tan_pkg::TILT_W-1:0]    tilt_z_o,
  output logic                                 zero_length_o
);
  import tan_pkg::*;

  localparam int unsigned IW     = $clog2(OVERSAMPLE);
  localparam int unsigned SW     = SAMPLE_W + IW;   // running sum width
  localparam int unsigned LEN_W  = 2 * SW;          // squared length width
  localparam int unsigned RING_W = AXES * SAMPLE_W;
  localparam int unsigned DIV_W  = ROOT_W + FRAC_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(OVERSAMPLE - 1);

  // Ring bookkeeping. Slots are written in order; until the first wrap, full_q
  // keeps the not yet written slot at the write pointer out of the running sum.
  logic [IW-1:0]     idx_q;
  logic              full_q;
  logic [RING_W-1:0] ring_rdata;
  logic [RING_W-1:0] ring_wdata;

  logic [SAMPLE_W-1:0] smp_q  [AXES];
  logic [SW-1:0]       sum_q  [AXES];
  logic [SW-1:0]       mag_c  [AXES];
  logic [ROOT_W-1:0]   magn_q [AXES];
  logic [ROOT_W:0]     drem_q [AXES];
  logic [QUO_W-1:0]    dlo_q  [AXES];
  logic [QUO_W-1:0]    quo_q  [AXES];
  logic [TILT_W-1:0]   tilt_c [AXES];
  logic [TILT_W-1:0]   tilt_q [AXES];

  logic [SW-1:0]     mul_op;
  logic [LEN_W-1:0]  sq_c;
  logic [LEN_W-1:0]  prod_q;
  logic [LEN_W-1:0]  len_q;
  logic              len_zero;
  logic [NORM_W-1:0] n_q;
  logic              norm_wide;
  logic [ROOT_W:0]   rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W+1:0] sq_rem_t;
  logic [ROOT_W+1:0] sq_trial;
  logic              sq_ge;
  logic              out_valid_q;
  logic              zl_q;

  assign ring_wdata = {smp_q[2], smp_q[1], smp_q[0]};

  tan_ram #(
    .WIDTH (RING_W),
    .DEPTH (OVERSAMPLE)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (idx_q),
    .wdata_i (ring_wdata),
    .raddr_i (idx_q),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.update) begin
      if (idx_q == LAST_IDX) begin
        idx_q  <= '0;
        full_q <= 1'b1;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    logic [SAMPLE_W-1:0] old_smp;
    logic [SW-1:0]       sum_upd;
    logic [DIV_W-1:0]    div_num;
    logic [ROOT_W:0]     dv_t;
    logic                dv_ge;
    logic [QUO_W-1:0]    m_lim;
    logic                pos;

    always_comb begin
      old_smp = full_q ? ring_rdata[g*SAMPLE_W +: SAMPLE_W] : '0;
      sum_upd = sum_q[g]
              + {{IW{smp_q[g][SAMPLE_W-1]}}, smp_q[g]}
              - {{IW{old_smp[SAMPLE_W-1]}}, old_smp};
      mag_c[g] = sum_q[g][SW-1] ? (~sum_q[g] + 1'b1) : sum_q[g];
      div_num  = DIV_W'({magn_q[g], {FRAC_W{1'b0}}}) + DIV_W'(root_q >> 1);
      dv_t     = {drem_q[g][ROOT_W-1:0], dlo_q[g][QUO_W-1]};
      dv_ge    = (dv_t >= {1'b0, root_q});
      m_lim    = (quo_q[g] > UNIT_Q14) ? UNIT_Q14 : quo_q[g];
      pos      = !sum_q[g][SW-1] && (sum_q[g] != '0);
      // The result points against the mean acceleration.
      if (len_zero) begin
        tilt_c[g] = '0;
      end else if (pos) begin
        tilt_c[g] = ~m_lim + 1'b1;
      end else begin
        tilt_c[g] = m_lim;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q[g] <= '0;
      end else if (cmd_i.update) begin
        sum_q[g] <= sum_upd;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.sq_first) begin
        magn_q[g] <= ROOT_W'(mag_c[g]);
      end else if (cmd_i.norm_step) begin
        magn_q[g] <= norm_wide ? (magn_q[g] << 4) : (magn_q[g] << 1);
      end
      if (cmd_i.div_init) begin
        drem_q[g] <= (ROOT_W + 1)'(div_num[DIV_W-1:QUO_W]);
        dlo_q[g]  <= div_num[QUO_W-1:0];
        quo_q[g]  <= '0;
      end else if (cmd_i.div_step) begin
        drem_q[g] <= dv_ge ? (dv_t - {1'b0, root_q}) : dv_t;
        dlo_q[g]  <= dlo_q[g] << 1;
        quo_q[g]  <= {quo_q[g][QUO_W-2:0], dv_ge};
      end
      if (cmd_i.out_load) begin
        tilt_q[g] <= tilt_c[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smp_q[0] <= accel_x_i;
      smp_q[1] <= accel_y_i;
      smp_q[2] <= accel_z_i;
    end
  end

  always_comb begin
    unique case (cmd_i.sq_axis)
      AXIS_X:  mul_op = mag_c[0];
      AXIS_Y:  mul_op = mag_c[1];
      AXIS_Z:  mul_op = mag_c[2];
      default: mul_op = '0;
    endcase
  end

  assign sq_c      = mul_op * mul_op;
  assign len_zero  = (len_q == '0);
  assign norm_wide = (n_q[NORM_W-1 -: 8] == 8'd0);

  // Restoring square root, one result bit per step.
  assign sq_rem_t = {rem_q[ROOT_W-1:0], n_q[NORM_W-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_ge    = (sq_rem_t >= sq_trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_prod) begin
      prod_q <= sq_c;
    end
    if (cmd_i.sq_first) begin
      len_q <= '0;
    end else if (cmd_i.sq_acc) begin
      len_q <= len_q + prod_q;
    end
    // Shift the squared length up by a power of four until one of its top two
    // bits is set; the magnitudes follow by the matching power of two.
    if (cmd_i.norm_init) begin
      n_q <= NORM_W'(len_q);
    end else if (cmd_i.norm_step) begin
      n_q <= norm_wide ? (n_q << 8) : (n_q << 2);
    end else if (cmd_i.sqrt_step) begin
      n_q <= n_q << 2;
    end
    if (cmd_i.sqrt_init) begin
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rem_q  <= sq_ge ? (ROOT_W + 1)'(sq_rem_t - sq_trial) : (ROOT_W + 1)'(sq_rem_t);
      root_q <= {root_q[ROOT_W-2:0], sq_ge};
    end
    if (cmd_i.out_load) begin
      zl_q <= len_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.len_zero  = len_zero;
  assign sts_o.norm_done = (n_q[NORM_W-1 -: 2] != 2'b00);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign tilt_x_o      = tilt_q[0];
  assign tilt_y_o      = tilt_q[1];
  assign tilt_z_o      = tilt_q[2];
  assign zero_length_o = zl_q;

  a_root_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> root_q[ROOT_W-1])
    else $error("square root of the normalized length lost its top bit");

  a_sqrt_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sqrt_step |=> rem_q <= {root_q, 1'b0})
    else $error("square root remainder exceeds twice the partial root");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> drem_q[0] < {1'b0, root_q})
    else $error("divider remainder not below the divisor");

  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && zl_q |-> tilt_q[0] == '0 && tilt_q[1] == '0 && tilt_q[2] == '0)
    else $error("zero-length result carries a nonzero component");

endmodule

// File: rtl/tilt_average_normalize_unit.sv
// Tilt average and normalize unit: moving window sum of accelerometer samples,
// turned into the negated unit vector in Q1.14. Uses tan_pkg, tan_ctrl, tan_datapath.
// The 3 to 9 normalizer steps, the 31-step square root and the 16-step divider lanes lie
// between an accepted transaction and a valid result; a zero sum skips them. A new
// transaction is accepted only once the previous result is loaded; a result not yet taken
// holds the next one back until the output register frees up.
// Reset: asynchronous, active low; clears the running sums, ring pointer and wrap flag, output valid and controller.
module tilt_average_normalize_unit #(
  parameter int unsigned OVERSAMPLE = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tan_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [tan_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [tan_pkg::SAMPLE_W-1:0] accel_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tan_pkg::TILT_W-1:0]   tilt_x_o,
  output logic signed [tan_pkg::TILT_W-1:0]   tilt_y_o,
  output logic signed [tan_pkg::TILT_W-1:0]   tilt_z_o,
  output logic                                zero_length_o
);
  import tan_pkg::*;

  tan_cmd_t cmd;
  tan_sts_t sts;

  tan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tan_datapath #(
    .OVERSAMPLE (OVERSAMPLE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .tilt_x_o      (tilt_x_o),
    .tilt_y_o      (tilt_y_o),
    .tilt_z_o      (tilt_z_o),
    .zero_length_o (zero_length_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench of tilt_average_normalize_unit: drives accelerometer samples
// through the valid/ready input, predicts the windowed, normalized tilt vector and checks
// each result. Depends on tan_pkg and the unit's RTL only.
module testbench;

  import tan_pkg::*;

  localparam int WIN         = 16;
  localparam int IDLE_PCT    = 29;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN       = 80;
  localparam int LIMIT       = 500000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TILT_W-1:0]   tilt_t;

  typedef struct {
    tilt_t tx;
    tilt_t ty;
    tilt_t tz;
    logic  zl;
  } tilt_result_t;

  typedef enum int {PICK_FULL, PICK_SMALL, PICK_EDGE} pick_e;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready_o;
  sample_t accel_x = '0;
  sample_t accel_y = '0;
  sample_t accel_z = '0;
  logic    out_valid_o;
  logic    out_ready = 1'b0;
  tilt_t   tilt_x_o;
  tilt_t   tilt_y_o;
  tilt_t   tilt_z_o;
  logic    zero_length_o;

  bit           gaps_on = 1'b1;
  int           fail_count = 0;
  int           cycle_count = 0;
  tilt_result_t tilt_expect_q[$];

  // Window state of the predictor.
  sample_t ring_x[WIN];
  sample_t ring_y[WIN];
  sample_t ring_z[WIN];
  int      win_slot = 0;
  int      win_sum_x = 0;
  int      win_sum_y = 0;
  int      win_sum_z = 0;

  tilt_average_normalize_unit #(.OVERSAMPLE(WIN)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .tilt_x_o      (tilt_x_o),
    .tilt_y_o      (tilt_y_o),
    .tilt_z_o      (tilt_z_o),
    .zero_length_o (zero_length_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // One component of -S/|S| in Q1.14, rounded half up in magnitude.
  function automatic tilt_t scale_axis(input int s, input int k, input logic [63:0] root);
    logic [63:0] mag_s;
    logic [63:0] q;
    mag_s = (s < 0) ? 64'(-longint'(s)) : 64'(s);
    if (mag_s == 0) return '0;
    q = ((mag_s << (FRAC_W + k)) + (root >> 1)) / root;
    if (q > UNIT_Q14) q = UNIT_Q14;
    return (s > 0) ? tilt_t'(-16'(q)) : tilt_t'(16'(q));
  endfunction

  function automatic tilt_result_t predict_tilt(input sample_t nx, input sample_t ny,
                                                input sample_t nz);
    tilt_result_t res;
    logic [63:0]  len_sq;
    logic [63:0]  root;
    int           k;
    win_sum_x += int'(nx) - int'(ring_x[win_slot]);
    win_sum_y += int'(ny) - int'(ring_y[win_slot]);
    win_sum_z += int'(nz) - int'(ring_z[win_slot]);
    ring_x[win_slot] = nx;
    ring_y[win_slot] = ny;
    ring_z[win_slot] = nz;
    win_slot = (win_slot == WIN - 1) ? 0 : win_slot + 1;
    len_sq = 64'(longint'(win_sum_x) * longint'(win_sum_x))
           + 64'(longint'(win_sum_y) * longint'(win_sum_y))
           + 64'(longint'(win_sum_z) * longint'(win_sum_z));
    res.tx = '0;
    res.ty = '0;
    res.tz = '0;
    res.zl = 1'b1;
    if (len_sq == 0) return res;
    // Scale the squared length up by powers of four to get a precise root.
    k = 0;
    while (k < 31 && (len_sq << (2 * (k + 1))) < (64'd1 << 62)) k++;
    root = floor_sqrt(len_sq << (2 * k));
    res.tx = scale_axis(win_sum_x, k, root);
    res.ty = scale_axis(win_sum_y, k, root);
    res.tz = scale_axis(win_sum_z, k, root);
    res.zl = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i) begin : check_result
    tilt_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (tilt_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected transaction: x=%0d y=%0d z=%0d zero=%0b",
                   tilt_x_o, tilt_y_o, tilt_z_o, zero_length_o);
      end else begin
        want = tilt_expect_q.pop_front();
        if (tilt_x_o !== want.tx || tilt_y_o !== want.ty || tilt_z_o !== want.tz ||
            zero_length_o !== want.zl) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"mismatch: expected x=%0d y=%0d z=%0d zero=%0b, ",
                      "got x=%0d y=%0d z=%0d zero=%0b"},
                     want.tx, want.ty, want.tz, want.zl,
                     tilt_x_o, tilt_y_o, tilt_z_o, zero_length_o);
        end
      end
    end
  end

  task automatic push_sample(input sample_t sx, input sample_t sy, input sample_t sz);
    tilt_result_t want;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk_i);
    end
    @(posedge clk_i);
    in_valid <= 1'b1;
    accel_x  <= sx;
    accel_y  <= sy;
    accel_z  <= sz;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid <= 1'b0;
    want = predict_tilt(sx, sy, sz);
    tilt_expect_q.push_back(want);
  endtask

  function automatic pick_e random_pick();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return PICK_FULL;
    if (roll < 85) return PICK_SMALL;
    return PICK_EDGE;
  endfunction

  function automatic sample_t draw_sample(input pick_e how);
    sample_t v;
    case (how)
      PICK_FULL:  v = sample_t'($urandom_range(0, 65535));
      PICK_SMALL: v = sample_t'(int'($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 5))
          0:       v = 16'sh8000;
          1:       v = 16'sh8001;
          2:       v = -16'sd1;
          3:       v = 16'sd0;
          4:       v = 16'sd1;
          default: v = 16'sh7fff;
        endcase
      end
    endcase
    return v;
  endfunction

  // An all-zero window right after reset has no direction.
  task automatic test_empty_window();
    push_sample(16'sd0, 16'sd0, 16'sd0);
  endtask

  // A sample and its negation cancel while the rest of the window is still zero.
  task automatic test_cancel_to_zero();
    push_sample(16'sd12345, -16'sd300, 16'sd7);
    push_sample(-16'sd12345, 16'sd300, -16'sd7);
  endtask

  task automatic test_axis_extremes();
    push_sample(16'sh7fff, 16'sd0, 16'sd0);
    push_sample(16'sh8000, 16'sd0, 16'sd0);
    push_sample(16'sd0, 16'sh8000, 16'sd0);
    push_sample(16'sd0, 16'sd0, 16'sh7fff);
    push_sample(16'sh8000, 16'sh8000, 16'sh8000);
    push_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    push_sample(16'sd1, -16'sd1, 16'sd0);
    push_sample(-16'sd1, 16'sd0, 16'sd1);
    push_sample(16'sh5555, 16'shaaaa, 16'sh00ff);
    push_sample(16'shff00, 16'sh0f0f, 16'shf0f0);
    push_sample(16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_mixed(input int count);
    repeat (count)
      push_sample(draw_sample(random_pick()), draw_sample(random_pick()),
                  draw_sample(random_pick()));
  endtask

  // Bursts of sample/negation pairs: once the window holds only pairs, every
  // second result sees a zero sum.
  task automatic test_cancel_pairs(input int bursts);
    sample_t vx, vy, vz;
    repeat (bursts) begin
      repeat (12) begin
        vx = draw_sample(random_pick());
        vy = draw_sample(random_pick());
        vz = draw_sample(random_pick());
        if (vx == 16'sh8000) vx = 16'sh8001;
        if (vy == 16'sh8000) vy = 16'sh8001;
        if (vz == 16'sh8000) vz = 16'sh8001;
        push_sample(vx, vy, vz);
        push_sample(-vx, -vy, -vz);
      end
    end
  endtask

  // A constant sample held past a full window; small values give short sums.
  task automatic test_constant_window(input int bursts);
    sample_t vx, vy, vz;
    repeat (bursts) begin
      vx = draw_sample(random_pick());
      vy = draw_sample(random_pick());
      vz = draw_sample(random_pick());
      repeat (WIN + 4) push_sample(vx, vy, vz);
    end
  endtask

  initial begin
    foreach (ring_x[i]) begin
      ring_x[i] = '0;
      ring_y[i] = '0;
      ring_z[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_window();
    test_cancel_to_zero();
    test_axis_extremes();
    test_random_mixed(350);
    test_cancel_pairs(4);
    test_constant_window(3);
    gaps_on = 1'b0;
    test_random_mixed(200);
    gaps_on = 1'b1;

    while (tilt_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: tilt_average_normalize_unit.f
rtl/tan_pkg.sv
rtl/tan_ram.sv
rtl/tan_ctrl.sv
rtl/tan_datapath.sv
rtl/tilt_average_normalize_unit.sv
tb/testbench.sv
